### src/mie_pkg.sv
// Package for the modular inverse block: microcode types, step addresses and the program table.
`default_nettype none
package mie_pkg;

	localparam int PC_W = 4;

	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations selected by a control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIVSTEP,
		OP_SETR1,
		OP_DIVSET,
		OP_ITER,
		OP_REDUCE,
		OP_EMITOK,
		OP_EMITNO
	} op_t;

	// Conditions under which a step repeats itself.
	typedef enum logic [1:0] {
		H_NONE,
		H_NOINPUT,
		H_DIVBUSY,
		H_OUTBUSY
	} hold_t;

	// Conditions under which a step branches to its target.
	typedef enum logic [2:0] {
		J_NEVER,
		J_ALWAYS,
		J_MZERO,
		J_R1ZERO,
		J_R0NOT1
	} jmp_t;

	typedef struct packed {
		op_t   op;
		hold_t hold;
		jmp_t  jmp;
		pc_t   target;
	} ucode_t;

	// Control from the sequencer to the datapath and output register.
	typedef struct packed {
		op_t  op;
		logic en;
	} ctl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic m_zero;
		logic div_busy;
		logic r1_zero;
		logic r0_not1;
	} stat_t;

	localparam pc_t PC_LOAD   = 4'd0;
	localparam pc_t PC_CHKM   = 4'd1;
	localparam pc_t PC_DIVA   = 4'd2;
	localparam pc_t PC_SETR1  = 4'd3;
	localparam pc_t PC_DIVSET = 4'd4;
	localparam pc_t PC_DIVQ   = 4'd5;
	localparam pc_t PC_ITER   = 4'd6;
	localparam pc_t PC_CHKG   = 4'd7;
	localparam pc_t PC_REDUCE = 4'd8;
	localparam pc_t PC_EMITOK = 4'd9;
	localparam pc_t PC_EMITNO = 4'd10;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			PC_LOAD:   w = '{op: OP_LOAD,    hold: H_NOINPUT, jmp: J_NEVER,  target: PC_LOAD};
			PC_CHKM:   w = '{op: OP_NOP,     hold: H_NONE,    jmp: J_MZERO,  target: PC_EMITNO};
			PC_DIVA:   w = '{op: OP_DIVSTEP, hold: H_DIVBUSY, jmp: J_NEVER,  target: PC_LOAD};
			PC_SETR1:  w = '{op: OP_SETR1,   hold: H_NONE,    jmp: J_NEVER,  target: PC_LOAD};
			PC_DIVSET: w = '{op: OP_DIVSET,  hold: H_NONE,    jmp: J_R1ZERO, target: PC_CHKG};
			PC_DIVQ:   w = '{op: OP_DIVSTEP, hold: H_DIVBUSY, jmp: J_NEVER,  target: PC_LOAD};
			PC_ITER:   w = '{op: OP_ITER,    hold: H_NONE,    jmp: J_ALWAYS, target: PC_DIVSET};
			PC_CHKG:   w = '{op: OP_NOP,     hold: H_NONE,    jmp: J_R0NOT1, target: PC_EMITNO};
			PC_REDUCE: w = '{op: OP_REDUCE,  hold: H_NONE,    jmp: J_NEVER,  target: PC_LOAD};
			PC_EMITOK: w = '{op: OP_EMITOK,  hold: H_OUTBUSY, jmp: J_ALWAYS, target: PC_LOAD};
			PC_EMITNO: w = '{op: OP_EMITNO,  hold: H_OUTBUSY, jmp: J_ALWAYS, target: PC_LOAD};
			default:   w = '{op: OP_NOP,     hold: H_NONE,    jmp: J_ALWAYS, target: PC_LOAD};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### src/mie_seq.sv
// Microcode sequencer: step counter, program table lookup, holds and conditional jumps.
`default_nettype none
module mie_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_busy,
	input  wire mie_pkg::stat_t stat,
	output mie_pkg::ctl_t      ctl,
	output logic               in_stall
);

	mie_pkg::pc_t   pc_q;
	mie_pkg::pc_t   pc_next;
	mie_pkg::ucode_t uw;
	logic           hold;
	logic           take;

	assign uw = mie_pkg::ucode_rom(pc_q);

	always_comb begin
		case (uw.hold)
			mie_pkg::H_NONE:    hold = 1'b0;
			mie_pkg::H_NOINPUT: hold = !in_valid;
			mie_pkg::H_DIVBUSY: hold = stat.div_busy;
			mie_pkg::H_OUTBUSY: hold = out_busy;
			default:            hold = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.jmp)
			mie_pkg::J_NEVER:  take = 1'b0;
			mie_pkg::J_ALWAYS: take = 1'b1;
			mie_pkg::J_MZERO:  take = stat.m_zero;
			mie_pkg::J_R1ZERO: take = stat.r1_zero;
			mie_pkg::J_R0NOT1: take = stat.r0_not1;
			default:           take = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			pc_next = pc_q;
		end else if (take) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + mie_pkg::PC_W'(1);
		end
	end

	// A division step works every cycle; only waits on a handshake suppress the operation.
	always_comb begin
		ctl.op   = uw.op;
		ctl.en   = !(hold && (uw.hold != mie_pkg::H_DIVBUSY));
		in_stall = (uw.op != mie_pkg::OP_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mie_pkg::PC_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
`default_nettype wire

### src/mie_dp.sv
// Datapath: remainder and coefficient registers with a shared bit-serial divider.
`default_nettype none
module mie_dp #(
	parameter int WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mie_pkg::ctl_t   ctl,
	input  wire logic [WIDTH-1:0] a_in,
	input  wire logic [WIDTH-1:0] m_in,
	output mie_pkg::stat_t       stat,
	output logic [WIDTH-1:0]     res_inv
);

	localparam int CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0] mod_q, r0_q, r1_q, u0_q, u1_q;
	logic [WIDTH-1:0] num_q, den_q, rem_q, acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             par_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             qbit;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] acc_next;

	// One restoring division step; the quotient bit also builds q * u1 in the accumulator.
	always_comb begin
		trial    = {rem_q, num_q[WIDTH-1]};
		diff     = trial - {1'b0, den_q};
		qbit     = !diff[WIDTH];
		rem_next = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		acc_next = {acc_q[WIDTH-2:0], 1'b0} + (qbit ? u1_q : '0);
	end

	// An even number of steps leaves a negative coefficient, so it is folded into range.
	always_comb begin
		if (!par_q && (u0_q != '0)) begin
			res_inv = mod_q - u0_q;
		end else begin
			res_inv = u0_q;
		end
	end

	always_comb begin
		stat.m_zero   = (mod_q == '0);
		stat.div_busy = (cnt_q != '0);
		stat.r1_zero  = (r1_q == '0);
		stat.r0_not1  = (r0_q != WIDTH'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.en) begin
			case (ctl.op)
				mie_pkg::OP_LOAD:    cnt_q <= CNT_W'(WIDTH - 1);
				mie_pkg::OP_DIVSET:  cnt_q <= CNT_W'(WIDTH - 1);
				mie_pkg::OP_DIVSTEP: cnt_q <= cnt_q - CNT_W'(1);
				default:             cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.op)
				mie_pkg::OP_LOAD: begin
					mod_q <= m_in;
					r0_q  <= m_in;
					u0_q  <= '0;
					u1_q  <= WIDTH'(1);
					par_q <= 1'b0;
					num_q <= a_in;
					den_q <= m_in;
					rem_q <= '0;
					acc_q <= '0;
				end
				mie_pkg::OP_DIVSTEP: begin
					rem_q <= rem_next;
					acc_q <= acc_next;
					num_q <= {num_q[WIDTH-2:0], 1'b0};
				end
				mie_pkg::OP_SETR1: begin
					r1_q <= rem_q;
				end
				mie_pkg::OP_DIVSET: begin
					num_q <= r0_q;
					den_q <= r1_q;
					rem_q <= '0;
					acc_q <= '0;
				end
				mie_pkg::OP_ITER: begin
					r0_q  <= r1_q;
					r1_q  <= rem_q;
					u0_q  <= u1_q;
					u1_q  <= u0_q + acc_q;
					par_q <= !par_q;
				end
				mie_pkg::OP_REDUCE: begin
					if (u0_q >= mod_q) begin
						u0_q <= u0_q - mod_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: operand sizing, sequencer, datapath and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  input    | in_valid / in_stall  | value[31:0], modulus[31:0]
//  output   | out_valid / out_stall| inverse[31:0], exists
//
// One item at a time. Each Euclid step runs the bit-serial divider, which makes one quotient
// bit per cycle; the number of Euclid steps is at most about 1.44*WIDTH. A zero modulus
// skips the division and goes straight to the no-inverse result.
// Reset clears the step counter, the divider count and the output valid flag only.
// A finished result waits in the output register while the next transaction is taken in.
`default_nettype none
module modular_inverse_ext_euclid #(
	parameter int WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] value,
	input  wire logic [31:0] modulus,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      inverse,
	output logic             exists
);

	mie_pkg::ctl_t  ctl;
	mie_pkg::stat_t stat;

	logic [WIDTH+31:0] a_wide, m_wide, inv_wide;
	logic [WIDTH-1:0]  res_inv;
	logic              out_valid_q;
	logic [31:0]       inverse_q;
	logic              exists_q;
	logic              out_busy;
	logic              emit;

	// Operands are cut or padded to WIDTH bits; the result is cut or padded back to 32.
	assign a_wide   = {WIDTH'(0), value};
	assign m_wide   = {WIDTH'(0), modulus};
	assign inv_wide = {32'd0, res_inv};

	assign out_busy = out_valid_q && out_stall;
	assign emit     = ctl.en && ((ctl.op == mie_pkg::OP_EMITOK) || (ctl.op == mie_pkg::OP_EMITNO));

	mie_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.stat     (stat),
		.ctl      (ctl),
		.in_stall (in_stall)
	);

	mie_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.a_in    (a_wide[WIDTH-1:0]),
		.m_in    (m_wide[WIDTH-1:0]),
		.stat    (stat),
		.res_inv (res_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctl.op == mie_pkg::OP_EMITOK) begin
				inverse_q <= inv_wide[31:0];
				exists_q  <= 1'b1;
			end else begin
				inverse_q <= '0;
				exists_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign inverse   = inverse_q;
	assign exists    = exists_q;

endmodule
`default_nettype wire

### sim/modular_inverse_ext_euclid_tb.sv
// Self-checking testbench for the modular inverse block, with random and directed value/modulus pairs.
module modular_inverse_ext_euclid_tb;

	localparam int unsigned EUCLID_MAX_STEPS = 2 * 32 + 4;
	localparam int unsigned STUCK_LIMIT      = 20000;
	localparam int unsigned DRAIN_CYCLES     = 2000;
	localparam int unsigned HOLDOFF_CYCLES   = 1500;

	typedef struct {
		logic [31:0] value;
		logic [31:0] modulus;
		logic [31:0] inverse;
		logic        exists;
	} inverse_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] value;
	logic [31:0] modulus;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] inverse;
	logic        exists;

	inverse_result_t pending_inverses[$];
	inverse_result_t oldest;
	int unsigned     errors;
	int unsigned     stuck_cycles;
	int unsigned     holdoff_len;
	bit              idle_on;

	modular_inverse_ext_euclid #(
		.WIDTH(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.modulus  (modulus),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inverse  (inverse),
		.exists   (exists)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Extended Euclid with the Bezout coefficient kept as a magnitude; its sign
	// alternates with the number of steps taken.
	function automatic void modinv_predict(input logic [31:0] a, input logic [31:0] m,
			output logic [31:0] inv, output logic ok);
		longint unsigned r0, r1, u0, u1, q, r, u;
		int unsigned steps;
		inv = '0;
		ok  = 1'b0;
		if (m == 32'd0)
			return;
		r0 = m;
		r1 = a % m;
		u0 = 0;
		u1 = 1;
		steps = 0;
		while (r1 != 0 && steps < EUCLID_MAX_STEPS) begin
			q  = r0 / r1;
			r  = r0 - q * r1;
			u  = u0 + q * u1;
			r0 = r1;
			r1 = r;
			u0 = u1;
			u1 = u;
			steps++;
		end
		if (r1 != 0 || r0 != 1)
			return;
		ok = 1'b1;
		u0 = u0 % m;
		if ((steps % 2) == 0 && u0 != 0)
			u0 = m - u0;
		inv = u0[31:0];
	endfunction

	function automatic logic [31:0] rand_bits(input int unsigned w);
		return (w >= 32) ? 32'($urandom) : (32'($urandom) & ((32'd1 << w) - 32'd1));
	endfunction

	task automatic send_pair(input logic [31:0] v, input logic [31:0] m);
		inverse_result_t exp_res;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		modulus  <= m;
		do
			@(posedge clk);
		while (in_stall);
		exp_res.value   = v;
		exp_res.modulus = m;
		modinv_predict(v, m, exp_res.inverse, exp_res.exists);
		pending_inverses.push_back(exp_res);
	endtask

	// Moduli of random bit length keep the Euclid step count, and so the run, short.
	task automatic send_random_pair(input int unsigned max_w);
		int unsigned w;
		int unsigned f;
		logic [31:0] m;
		logic [31:0] v;
		w = $urandom_range(1, max_w);
		m = rand_bits(w);
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: begin
				f = $urandom_range(2, 9);
				v = rand_bits(w) * f;
				m = m * f;
			end
			2: v = m + $urandom_range(0, 2) - 32'd1;
			default: v = rand_bits(w);
		endcase
		send_pair(v, m);
	endtask

	task automatic test_directed();
		send_pair(32'd0, 32'd0);
		send_pair(32'hFFFF_FFFF, 32'd0);
		send_pair(32'd5, 32'd0);
		send_pair(32'd0, 32'd1);
		send_pair(32'hFFFF_FFFF, 32'd1);
		send_pair(32'd0, 32'd7);
		send_pair(32'd3, 32'd7);
		send_pair(32'd10, 32'd7);
		send_pair(32'd2, 32'd4);
		send_pair(32'd6, 32'd9);
		send_pair(32'd1, 32'd2);
		send_pair(32'hFFFF_FFFF, 32'd2);
		send_pair(32'd1, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'h8000_0000, 32'hFFFF_FFFF);
		send_pair(32'd3, 32'hFFFF_FFFB);
		send_pair(32'hFFFF_FFFA, 32'hFFFF_FFFB);
		send_pair(32'hFFFF_FFFF, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h8000_0000);
		// Consecutive Fibonacci numbers need the most Euclid steps.
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	task automatic test_mixed_widths(input int unsigned count);
		repeat (count) send_random_pair(32);
	endtask

	task automatic test_full_width(input int unsigned count);
		repeat (count) send_pair($urandom, $urandom);
	endtask

	// The receiver holds off while the sender keeps offering, so the block fills up.
	task automatic test_holdoff();
		holdoff_len = HOLDOFF_CYCLES;
		repeat (8) send_random_pair(32);
	endtask

	task automatic test_no_idle(input int unsigned count);
		idle_on = 1'b0;
		repeat (count) send_random_pair(32);
	endtask

	initial begin : result_stall
		int unsigned n;
		bit          holdoff_done;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			n = 0;
			if (holdoff_len != 0 && !holdoff_done) begin
				n = holdoff_len;
				holdoff_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 8);
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_inverses.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual inverse %h exists %b",
					$time, inverse, exists);
				errors++;
			end else begin
				oldest = pending_inverses.pop_front();
				if (inverse !== oldest.inverse) begin
					$display("%0t: inverse of %h mod %h: expected %h, actual %h", $time,
						oldest.value, oldest.modulus, oldest.inverse, inverse);
					errors++;
				end
				if (exists !== oldest.exists) begin
					$display("%0t: exists for %h mod %h: expected %b, actual %b", $time,
						oldest.value, oldest.modulus, oldest.exists, exists);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		holdoff_len  = 0;
		idle_on      = 1'b1;
		in_valid <= 1'b0;
		value    <= '0;
		modulus  <= '0;
		arst_n   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mixed_widths(450);
		test_holdoff();
		test_full_width(200);
		test_no_idle(220);
		in_valid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
